// ===== hdl/battery_current_voltage_filter_unit_assert.svh =====
// Assertion macros used by the checker file of the filter unit.
`ifndef BATTERY_CURRENT_VOLTAGE_FILTER_UNIT_ASSERT_SVH
`define BATTERY_CURRENT_VOLTAGE_FILTER_UNIT_ASSERT_SVH

// Antecedent in this cycle, consequent in the next one; reset masks the check.
`define BCVF_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("bcvf next-cycle check failed");

// Antecedent and consequent in the same cycle; reset masks the check.
`define BCVF_ASSERT_SAME(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("bcvf same-cycle check failed");

// Next-cycle check that also runs while reset is high.
`define BCVF_ASSERT_RESET(lbl, clk_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) (ante) |=> (cons)) \
    else $error("bcvf reset check failed");

`endif

// ===== hdl/bcvf_pkg.sv =====
package bcvf_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // shared divider geometry
  localparam int STEP_W = 7;
  localparam int DVD_W  = 64;
  localparam int DSR_W  = 40;
  localparam int QUO_W  = 34;

  // scaled numerator width and sensitivity fraction bits
  localparam int MAG_W     = 40;
  localparam int SENS_FRAC = 8;
  localparam int OFFSET_MV = 330;

  localparam logic [CFG_IDX_W-1:0] REG_VREF_MV   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CUR_SENS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VOLT_SENS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CUR_TAU   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_VOLT_TAU  = 3'd4;

  localparam logic [CFG_DATA_W-1:0] RST_VREF_MV   = 16'd3300;
  localparam logic [CFG_DATA_W-1:0] RST_CUR_SENS  = 16'd10240;
  localparam logic [CFG_DATA_W-1:0] RST_VOLT_SENS = 16'd25600;

  typedef struct packed {
    logic [31:0] timestamp_us;
    logic [15:0] current_sample;
    logic [15:0] voltage_sample;
  } sample_t;

  typedef struct packed {
    logic signed [31:0] current_amps;
    logic signed [31:0] voltage_volts;
    logic signed [31:0] power_watts;
  } result_t;

  typedef struct packed {
    logic              start;
    logic [DVD_W-1:0]  dividend;
    logic [DSR_W-1:0]  divisor;
    logic [STEP_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic             ovf;
    logic [QUO_W-1:0] quo;
    logic [DSR_W-1:0] rem;
  } div_resp_t;

endpackage

// ===== hdl/bcvf_div.sv =====
// Restoring divider, one quotient bit per cycle, dividend fed MSB first.
module bcvf_div (
  input  logic                 clk,
  input  logic                 rst,
  input  bcvf_pkg::div_req_t   req,
  output bcvf_pkg::div_resp_t  resp
);

  localparam int DVD_W  = bcvf_pkg::DVD_W;
  localparam int DSR_W  = bcvf_pkg::DSR_W;
  localparam int QUO_W  = bcvf_pkg::QUO_W;
  localparam int STEP_W = bcvf_pkg::STEP_W;

  logic              busy;
  logic              done;
  logic [STEP_W-1:0] cnt;
  logic [DVD_W-1:0]  dvd;
  logic [DSR_W-1:0]  dsr;
  logic [DSR_W-1:0]  rem;
  logic [QUO_W-1:0]  quo;
  logic              ovf;
  logic [DSR_W:0]    shifted;
  logic [DSR_W:0]    trial;
  logic              fits;
  logic              load;

  assign load    = req.start && !busy;
  assign shifted = {rem, dvd[DVD_W-1]};
  assign fits    = shifted >= {1'b0, dsr};
  assign trial   = shifted - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (load) begin
        busy <= 1'b1;
        cnt  <= req.steps;
      end else if (busy) begin
        cnt <= cnt - STEP_W'(1);
        if (cnt == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // quotient keeps its low bits; a one shifted off the top marks overflow
  always_ff @(posedge clk) begin
    if (load) begin
      dvd <= req.dividend;
      dsr <= req.divisor;
      rem <= '0;
      quo <= '0;
      ovf <= 1'b0;
    end else if (busy) begin
      dvd <= dvd << 1;
      rem <= fits ? trial[DSR_W-1:0] : shifted[DSR_W-1:0];
      quo <= {quo[QUO_W-2:0], fits};
      ovf <= ovf | quo[QUO_W-1];
    end
  end

  assign resp.done = done;
  assign resp.ovf  = ovf;
  assign resp.quo  = quo;
  assign resp.rem  = rem;

endmodule

// ===== hdl/battery_current_voltage_filter_unit.sv =====
// Channel  | Signals                            | Direction | Moves
// sample   | sample_valid, sample_stall, sample | in        | timestamp and two ADC samples
// result   | result_valid, result_stall, result | out       | filtered amps, volts, watts
// cfg      | cfg_write, cfg_index, cfg_data     | in        | one register write per cycle
//
// One transaction at a time; each bypassed filter (tau of zero) skips its divider run.
// Sample time is set by the shared restoring divider, one quotient bit per cycle,
// run for both scalings (FRAC_BITS + 49 steps) and both filter updates (64 steps).
// Reset is synchronous: registers return to defaults, state and levels clear.
// A finished result sits in the output register; the next sample is taken while
// it waits, and only the final load waits for result_stall to drop.
module battery_current_voltage_filter_unit #(
  parameter int ADC_BITS  = 16,
  parameter int FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                sample_valid,
  output logic                                sample_stall,
  input  bcvf_pkg::sample_t                   sample,
  output logic                                result_valid,
  input  logic                                result_stall,
  output bcvf_pkg::result_t                   result,
  input  logic                                cfg_write,
  input  logic [bcvf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bcvf_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int STEP_W = bcvf_pkg::STEP_W;
  localparam int DVD_W  = bcvf_pkg::DVD_W;
  localparam int DSR_W  = bcvf_pkg::DSR_W;
  localparam int QUO_W  = bcvf_pkg::QUO_W;
  localparam int MAG_W  = bcvf_pkg::MAG_W;

  localparam logic [63:0] FULL64 = (64'd1 << ADC_BITS) - 64'd1;
  // 330 mV sensor offset expressed in vref*sample units
  localparam logic [33:0] OFFSET = 34'(64'(bcvf_pkg::OFFSET_MV) * FULL64);
  localparam logic [STEP_W-1:0] SCALE_STEPS =
    STEP_W'(MAG_W + bcvf_pkg::SENS_FRAC + FRAC_BITS + 1);
  localparam logic [STEP_W-1:0] FILTER_STEPS = STEP_W'(DVD_W);
  localparam logic [63:0] HALF_LSB = 64'd1 << (FRAC_BITS - 1);
  localparam logic [31:0] SAT_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] SAT_MIN = 32'h8000_0000;

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_CUR_MUL   = 4'd1;
  localparam logic [3:0] S_CUR_DIV   = 4'd2;
  localparam logic [3:0] S_CUR_WAIT  = 4'd3;
  localparam logic [3:0] S_VOL_MUL   = 4'd4;
  localparam logic [3:0] S_VOL_DIV   = 4'd5;
  localparam logic [3:0] S_VOL_WAIT  = 4'd6;
  localparam logic [3:0] S_CFLT_MUL  = 4'd7;
  localparam logic [3:0] S_CFLT_DIV  = 4'd8;
  localparam logic [3:0] S_CFLT_WAIT = 4'd9;
  localparam logic [3:0] S_VFLT_MUL  = 4'd10;
  localparam logic [3:0] S_VFLT_DIV  = 4'd11;
  localparam logic [3:0] S_VFLT_WAIT = 4'd12;
  localparam logic [3:0] S_PWR_MUL   = 4'd13;
  localparam logic [3:0] S_OUT       = 4'd14;

  // sensitivity * full scale, done as shift and subtract
  function automatic logic [DSR_W-1:0] full_times(input logic [15:0] s);
    return (DSR_W'(s) << ADC_BITS) - DSR_W'(s);
  endfunction

  // tau in ms to us: t*1024 - t*16 - t*8
  function automatic logic [25:0] tau_us(input logic [15:0] t);
    logic [25:0] w;
    w = 26'(t);
    return (w << 10) - (w << 4) - (w << 3);
  endfunction

  function automatic logic [31:0] abs32(input logic [31:0] x);
    return x[31] ? (~x + 32'd1) : x;
  endfunction

  function automatic logic [31:0] sat36(input logic [35:0] s);
    if (s[35] && !(&s[34:31])) begin
      return SAT_MIN;
    end
    if (!s[35] && (|s[34:31])) begin
      return SAT_MAX;
    end
    return s[31:0];
  endfunction

  // round the doubled quotient to nearest, apply sign and saturate
  function automatic logic [31:0] scale_fix(input logic [QUO_W-1:0] q, input logic ov,
                                            input logic neg, input logic zero);
    logic [QUO_W:0]   sum;
    logic [QUO_W-1:0] rq;
    sum = {1'b0, q} + (QUO_W+1)'(1);
    rq  = sum[QUO_W:1];
    if (zero) begin
      return '0;
    end
    if (ov) begin
      return neg ? SAT_MIN : SAT_MAX;
    end
    if (neg) begin
      return (rq > QUO_W'(SAT_MIN)) ? SAT_MIN : (~rq[31:0] + 32'd1);
    end
    return (rq > QUO_W'(SAT_MAX)) ? SAT_MAX : rq[31:0];
  endfunction

  logic [3:0]  state;
  logic [15:0] vref_mv;
  logic [15:0] cur_sens;
  logic [15:0] volt_sens;
  logic [15:0] cur_tau;
  logic [15:0] volt_tau;
  logic [31:0] last_ts;
  logic [31:0] cur_level;
  logic [31:0] volt_level;

  logic [31:0] dt;
  logic [15:0] cur_s;
  logic [15:0] vol_s;
  logic [31:0] cur_raw;
  logic [31:0] volt_raw;
  logic [63:0] prod;
  logic        sc_neg;
  logic        sc_zero;
  logic        f_neg;
  logic        p_neg;
  bcvf_pkg::result_t res;

  logic        accept;
  logic        mul_en;
  logic [31:0] mul_a;
  logic [31:0] mul_b;

  logic [31:0] pos;
  logic        cur_neg;
  logic [33:0] cur_m;
  logic [31:0] scaled;

  logic        sel_volt;
  logic [31:0] f_raw;
  logic [31:0] f_lvl;
  logic [15:0] f_tau;
  logic [32:0] f_diff;
  logic [32:0] f_diff_neg;
  logic [31:0] f_mag;
  logic [DSR_W-1:0] f_d;
  logic        f_rnd;
  logic [QUO_W:0] f_q;
  logic [35:0] f_step;
  logic [35:0] f_sum;
  logic [31:0] f_new;

  logic [63:0] p_sum;
  logic [63:0] p_q;
  logic [31:0] power;
  logic        out_load;

  bcvf_pkg::div_req_t  div_req;
  bcvf_pkg::div_resp_t div_resp;

  assign sample_stall = (state != S_IDLE);
  assign accept       = sample_valid && !sample_stall;
  assign out_load     = (state == S_OUT) && (!result_valid || !result_stall);

  // scaling numerator: |vref*sample - offset| for current, vref*sample for voltage
  assign pos     = prod[31:0];
  assign cur_neg = {2'b0, pos} < OFFSET;
  assign cur_m   = cur_neg ? (OFFSET - {2'b0, pos}) : ({2'b0, pos} - OFFSET);
  assign scaled  = scale_fix(div_resp.quo, div_resp.ovf, sc_neg, sc_zero);

  // filter datapath, shared by both channels
  assign sel_volt   = (state inside {S_VFLT_MUL, S_VFLT_DIV, S_VFLT_WAIT});
  assign f_raw      = sel_volt ? volt_raw : cur_raw;
  assign f_lvl      = sel_volt ? volt_level : cur_level;
  assign f_tau      = sel_volt ? volt_tau : cur_tau;
  assign f_diff     = {f_raw[31], f_raw} - {f_lvl[31], f_lvl};
  assign f_diff_neg = ~f_diff + 33'd1;
  assign f_mag      = f_diff[32] ? f_diff_neg[31:0] : f_diff[31:0];
  assign f_d        = DSR_W'(tau_us(f_tau));
  assign f_rnd      = {div_resp.rem, 1'b0} >= {1'b0, f_d};
  assign f_q        = {1'b0, div_resp.quo} + (QUO_W+1)'(f_rnd);
  assign f_step     = f_neg ? (~{1'b0, f_q} + 36'd1) : {1'b0, f_q};
  assign f_sum      = {{4{f_lvl[31]}}, f_lvl} + f_step;
  assign f_new      = div_resp.ovf ? (f_neg ? SAT_MIN : SAT_MAX) : sat36(f_sum);

  // power: round the magnitude product at FRAC_BITS, then sign and saturate
  assign p_sum = prod + HALF_LSB;
  assign p_q   = p_sum >> FRAC_BITS;
  always_comb begin
    if (p_neg) begin
      power = (p_q > 64'(SAT_MIN)) ? SAT_MIN : (~p_q[31:0] + 32'd1);
    end else begin
      power = (p_q > 64'(SAT_MAX)) ? SAT_MAX : p_q[31:0];
    end
  end

  // shared multiplier operand select
  always_comb begin
    mul_en = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    case (state)
      S_CUR_MUL: begin
        mul_a = 32'(vref_mv);
        mul_b = 32'(cur_s);
      end
      S_VOL_MUL: begin
        mul_a = 32'(vref_mv);
        mul_b = 32'(vol_s);
      end
      S_CFLT_MUL, S_VFLT_MUL: begin
        mul_a = f_mag;
        mul_b = dt;
      end
      S_PWR_MUL: begin
        mul_a = abs32(cur_level);
        mul_b = abs32(volt_level);
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  // divider request select
  always_comb begin
    div_req.start    = (state inside {S_CUR_DIV, S_VOL_DIV, S_CFLT_DIV, S_VFLT_DIV});
    div_req.dividend = prod;
    div_req.divisor  = f_d;
    div_req.steps    = FILTER_STEPS;
    case (state)
      S_CUR_DIV: begin
        div_req.dividend = DVD_W'(cur_m) << (DVD_W - MAG_W);
        div_req.divisor  = full_times(cur_sens);
        div_req.steps    = SCALE_STEPS;
      end
      S_VOL_DIV: begin
        div_req.dividend = DVD_W'(pos) << (DVD_W - MAG_W);
        div_req.divisor  = full_times(volt_sens);
        div_req.steps    = SCALE_STEPS;
      end
      default: begin
      end
    endcase
  end

  bcvf_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .resp (div_resp)
  );

  // sequencer, configuration and filter state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      vref_mv      <= bcvf_pkg::RST_VREF_MV;
      cur_sens     <= bcvf_pkg::RST_CUR_SENS;
      volt_sens    <= bcvf_pkg::RST_VOLT_SENS;
      cur_tau      <= '0;
      volt_tau     <= '0;
      last_ts      <= '0;
      cur_level    <= '0;
      volt_level   <= '0;
      result_valid <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          bcvf_pkg::REG_VREF_MV:   vref_mv   <= cfg_data;
          bcvf_pkg::REG_CUR_SENS:  cur_sens  <= cfg_data;
          bcvf_pkg::REG_VOLT_SENS: volt_sens <= cfg_data;
          bcvf_pkg::REG_CUR_TAU:   cur_tau   <= cfg_data;
          bcvf_pkg::REG_VOLT_TAU:  volt_tau  <= cfg_data;
          default: begin
          end
        endcase
      end

      // drop the held result once taken; a new load overrides below
      if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            last_ts <= sample.timestamp_us;
            state   <= S_CUR_MUL;
          end
        end
        S_CUR_MUL:  state <= S_CUR_DIV;
        S_CUR_DIV:  state <= S_CUR_WAIT;
        S_CUR_WAIT: begin
          if (div_resp.done) begin
            state <= S_VOL_MUL;
          end
        end
        S_VOL_MUL:  state <= S_VOL_DIV;
        S_VOL_DIV:  state <= S_VOL_WAIT;
        S_VOL_WAIT: begin
          if (div_resp.done) begin
            state <= S_CFLT_MUL;
          end
        end
        S_CFLT_MUL: begin
          if (cur_tau == '0) begin
            cur_level <= cur_raw;
            state     <= S_VFLT_MUL;
          end else begin
            state <= S_CFLT_DIV;
          end
        end
        S_CFLT_DIV: state <= S_CFLT_WAIT;
        S_CFLT_WAIT: begin
          if (div_resp.done) begin
            cur_level <= f_new;
            state     <= S_VFLT_MUL;
          end
        end
        S_VFLT_MUL: begin
          if (volt_tau == '0) begin
            volt_level <= volt_raw;
            state      <= S_PWR_MUL;
          end else begin
            state <= S_VFLT_DIV;
          end
        end
        S_VFLT_DIV: state <= S_VFLT_WAIT;
        S_VFLT_WAIT: begin
          if (div_resp.done) begin
            volt_level <= f_new;
            state      <= S_PWR_MUL;
          end
        end
        S_PWR_MUL: state <= S_OUT;
        S_OUT: begin
          // hold until the output register is free
          if (out_load) begin
            result_valid <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      dt    <= sample.timestamp_us - last_ts;
      cur_s <= sample.current_sample;
      vol_s <= sample.voltage_sample;
    end
    if (mul_en) begin
      prod <= 64'(mul_a) * 64'(mul_b);
    end
    if (state == S_CUR_DIV) begin
      sc_neg  <= cur_neg;
      sc_zero <= (cur_m == '0);
    end
    if (state == S_VOL_DIV) begin
      sc_neg  <= 1'b0;
      sc_zero <= (pos == '0);
    end
    if ((state == S_CUR_WAIT) && div_resp.done) begin
      cur_raw <= scaled;
    end
    if ((state == S_VOL_WAIT) && div_resp.done) begin
      volt_raw <= scaled;
    end
    if (state inside {S_CFLT_MUL, S_VFLT_MUL}) begin
      f_neg <= f_diff[32];
    end
    if (state == S_PWR_MUL) begin
      p_neg <= cur_level[31] ^ volt_level[31];
    end
    if (out_load) begin
      res.current_amps  <= cur_level;
      res.voltage_volts <= volt_level;
      res.power_watts   <= power;
    end
  end

  assign result = res;

endmodule

// ===== hdl/bcvf_checker.sv =====
`include "battery_current_voltage_filter_unit_assert.svh"

module bcvf_checker (
  input logic clk,
  input logic rst,
  input logic sample_valid,
  input logic sample_stall,
  input logic result_valid,
  input logic result_stall
);

  // a held result stays offered until taken
  `BCVF_ASSERT_NEXT(a_result_hold, clk, rst, result_valid && result_stall, result_valid)

  // the unit works on one sample at a time
  `BCVF_ASSERT_NEXT(a_busy_after_accept, clk, rst, sample_valid && !sample_stall, sample_stall)

  // a new result only appears at the end of a busy stretch
  `BCVF_ASSERT_SAME(a_result_from_busy, clk, rst, $rose(result_valid), $past(sample_stall))

  // reset leaves the unit idle with nothing offered
  `BCVF_ASSERT_RESET(a_reset_idle, clk, rst, !sample_stall && !result_valid)

endmodule

bind battery_current_voltage_filter_unit bcvf_checker u_bcvf_checker (
  .clk          (clk),
  .rst          (rst),
  .sample_valid (sample_valid),
  .sample_stall (sample_stall),
  .result_valid (result_valid),
  .result_stall (result_stall)
);

// ===== test/battery_current_voltage_filter_unit_test.sv =====
`timescale 1ns / 1ps

module battery_current_voltage_filter_unit_test;

  // Fixed point format of every result field.
  localparam int Q_FRAC = 16;
  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
  localparam logic [63:0] ADC_FULL = 64'd65535;

  // Indexes past the register file; writes there must change nothing.
  localparam logic [bcvf_pkg::CFG_IDX_W-1:0] REG_UNUSED_LO  = 3'd5;
  localparam logic [bcvf_pkg::CFG_IDX_W-1:0] REG_UNUSED_MID = 3'd6;
  localparam logic [bcvf_pkg::CFG_IDX_W-1:0] REG_UNUSED_HI  = 3'd7;

  // Idling percentages of the random phases.
  localparam int IDLE_HEAVY = 74;
  localparam int IDLE_BOTH  = 35;

  localparam int NUM_PHASES      = 8;
  localparam int ITEMS_PER_PHASE = 242;
  // Receiver hold-off, long enough to back the block up into its input.
  localparam int HOLD_CYCLES     = 1500;
  // Long enough for one full sample with both filters on, plus margin.
  localparam int SETTLE_CYCLES   = 400;
  // Cycles with no transaction on either channel before the run is called dead.
  localparam int STALL_LIMIT     = 20000;

  typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_t;

  // One line of the directed stimulus: either a register write or a sample.
  // Sample rows with typed set carry their result written out by hand.
  typedef struct packed {
    row_kind_t                       kind;
    logic [bcvf_pkg::CFG_IDX_W-1:0]  index;
    logic [bcvf_pkg::CFG_DATA_W-1:0] data;
    bcvf_pkg::sample_t               item;
    logic                            typed;
    bcvf_pkg::result_t               want;
  } stim_row_t;

  localparam int NUM_ROWS = 29;
  localparam stim_row_t DIRECTED_ROWS [NUM_ROWS] = '{
    // Reset settings, filters bypassed: zero input is the -8.25 A offset.
    '{ROW_SAMPLE, '0, 16'd0, '{32'd0, 16'h0000, 16'h0000}, 1'b1,
      '{-32'sd540672, 32'sd0, 32'sd0}},
    // Full scale on both: 74.25 A, 33 V, 2450.25 W.
    '{ROW_SAMPLE, '0, 16'd0, '{32'd1000, 16'hFFFF, 16'hFFFF}, 1'b1,
      '{32'sd4866048, 32'sd2162688, 32'sd160579584}},
    '{ROW_SAMPLE, '0, 16'd0, '{32'hFFFF_FFFF, 16'h8000, 16'h1234}, 1'b0, '0},
    // Timestamp wraps past zero.
    '{ROW_SAMPLE, '0, 16'd0, '{32'd5, 16'h5555, 16'hAAAA}, 1'b0, '0},
    // Zero sensitivity: the scaled value pins to the rail of its sign.
    '{ROW_WRITE, bcvf_pkg::REG_CUR_SENS, 16'd0, '0, 1'b0, '0},
    '{ROW_WRITE, bcvf_pkg::REG_VOLT_SENS, 16'd0, '0, 1'b0, '0},
    '{ROW_SAMPLE, '0, 16'd0, '{32'd10, 16'h0000, 16'h0000}, 1'b1, '{Q_MIN, 32'sd0, 32'sd0}},
    '{ROW_SAMPLE, '0, 16'd0, '{32'd20, 16'hFFFF, 16'hFFFF}, 1'b1, '{Q_MAX, Q_MAX, Q_MAX}},
    // Reference of 330 mV puts full scale exactly on the offset: zero numerator.
    '{ROW_WRITE, bcvf_pkg::REG_VREF_MV, 16'd330, '0, 1'b0, '0},
    '{ROW_SAMPLE, '0, 16'd0, '{32'd30, 16'hFFFF, 16'h0000}, 1'b1, '{32'sd0, 32'sd0, 32'sd0}},
    // Writes past the register file must not alias onto real registers.
    '{ROW_WRITE, REG_UNUSED_LO, 16'hFFFF, '0, 1'b0, '0},
    '{ROW_WRITE, REG_UNUSED_MID, 16'h1234, '0, 1'b0, '0},
    '{ROW_WRITE, REG_UNUSED_HI, 16'h0001, '0, 1'b0, '0},
    '{ROW_SAMPLE, '0, 16'd0, '{32'd35, 16'h4000, 16'h8000}, 1'b1, '{Q_MIN, Q_MAX, Q_MIN}},
    // Largest reference against smallest sensitivity: every nonzero reading saturates.
    '{ROW_WRITE, bcvf_pkg::REG_VREF_MV, 16'hFFFF, '0, 1'b0, '0},
    '{ROW_WRITE, bcvf_pkg::REG_CUR_SENS, 16'd1, '0, 1'b0, '0},
    '{ROW_WRITE, bcvf_pkg::REG_VOLT_SENS, 16'd1, '0, 1'b0, '0},
    '{ROW_SAMPLE, '0, 16'd0, '{32'd40, 16'hFFFF, 16'hFFFF}, 1'b1, '{Q_MAX, Q_MAX, Q_MAX}},
    '{ROW_SAMPLE, '0, 16'd0, '{32'd50, 16'h0000, 16'h0000}, 1'b1, '{Q_MIN, 32'sd0, 32'sd0}},
    // Filters on: fast current, slowest voltage.
    '{ROW_WRITE, bcvf_pkg::REG_VREF_MV, bcvf_pkg::RST_VREF_MV, '0, 1'b0, '0},
    '{ROW_WRITE, bcvf_pkg::REG_CUR_SENS, bcvf_pkg::RST_CUR_SENS, '0, 1'b0, '0},
    '{ROW_WRITE, bcvf_pkg::REG_VOLT_SENS, bcvf_pkg::RST_VOLT_SENS, '0, 1'b0, '0},
    '{ROW_WRITE, bcvf_pkg::REG_CUR_TAU, 16'd1, '0, 1'b0, '0},
    '{ROW_WRITE, bcvf_pkg::REG_VOLT_TAU, 16'hFFFF, '0, 1'b0, '0},
    '{ROW_SAMPLE, '0, 16'd0, '{32'd1040, 16'hFFFF, 16'hFFFF}, 1'b0, '0},
    '{ROW_SAMPLE, '0, 16'd0, '{32'd1540, 16'h0000, 16'h0000}, 1'b0, '0},
    // Gain of ten on the current filter: overshoot, no clamp.
    '{ROW_SAMPLE, '0, 16'd0, '{32'd11540, 16'h8000, 16'h8000}, 1'b0, '0},
    // Same timestamp again: no time elapsed, levels hold.
    '{ROW_SAMPLE, '0, 16'd0, '{32'd11540, 16'h8000, 16'h8000}, 1'b0, '0},
    // Backward timestamp: huge elapsed time drives the filter sum to saturation.
    '{ROW_SAMPLE, '0, 16'd0, '{32'd60, 16'hFFFF, 16'h0000}, 1'b0, '0}
  };

  logic              clk;
  logic              rst;
  logic              sample_valid;
  logic              sample_stall;
  bcvf_pkg::sample_t sample;
  logic              result_valid;
  logic              result_stall;
  bcvf_pkg::result_t result;
  logic                            cfg_write;
  logic [bcvf_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [bcvf_pkg::CFG_DATA_W-1:0] cfg_data;

  // Predictor copy of the registers and the filter state.
  logic [15:0]        vref_setting;
  logic [15:0]        cur_sens_setting;
  logic [15:0]        volt_sens_setting;
  logic [15:0]        cur_tau_setting;
  logic [15:0]        volt_tau_setting;
  logic [31:0]        last_stamp_us;
  logic signed [31:0] current_level_q;
  logic signed [31:0] voltage_level_q;

  bcvf_pkg::result_t expected_readings[$];
  int      mismatch_count = 0;
  int      sender_idle_pct = 0;
  int      stall_pct = 0;
  bit      hold_requested = 1'b0;
  int      idle_cycles = 0;

  battery_current_voltage_filter_unit dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  function automatic logic signed [31:0] clamp_q16(input longint v);
    if (v > longint'(Q_MAX)) return Q_MAX;
    if (v < longint'(Q_MIN)) return Q_MIN;
    return v[31:0];
  endfunction

  // Round num * 2^24 / den to nearest, ties up, then apply the sign and clamp.
  // Compute one extra quotient bit for the rounding; cap at 2^40.
  function automatic logic signed [31:0] scale_reading(input logic [63:0] num,
                                                       input bit neg,
                                                       input logic [63:0] den);
    logic [63:0] twice;
    logic [63:0] q;
    if (num == 0) return '0;
    if (den == 0) return neg ? Q_MIN : Q_MAX;
    twice = (num << (bcvf_pkg::SENS_FRAC + Q_FRAC + 1)) / den;
    if (twice >= (64'd1 << 41)) begin
      q = 64'd1 << 40;
    end else begin
      q = (twice + 64'd1) >> 1;
      if (q > (64'd1 << 40)) q = 64'd1 << 40;
    end
    return neg ? clamp_q16(-longint'(q)) : clamp_q16(longint'(q));
  endfunction

  // Forward Euler step: level += dt*(raw - level)/(tau*1000), rounded half away
  // from zero on the magnitude. Zero tau passes raw straight through.
  function automatic logic signed [31:0] smooth_level(input logic signed [31:0] level,
                                                      input logic signed [31:0] raw,
                                                      input logic [31:0] dt,
                                                      input logic [15:0] tau);
    longint      diff;
    bit          neg;
    logic [63:0] mag;
    logic [63:0] den;
    logic [63:0] q;
    logic [63:0] rem;
    if (tau == 0) return raw;
    diff = longint'(raw) - longint'(level);
    neg = diff < 0;
    mag = neg ? 64'(-diff) : 64'(diff);
    mag = mag * 64'(dt);
    den = 64'(tau) * 64'd1000;
    q = mag / den;
    rem = mag % den;
    if ((rem << 1) >= den) q++;
    return neg ? clamp_q16(longint'(level) - longint'(q))
               : clamp_q16(longint'(level) + longint'(q));
  endfunction

  // Advance the predicted state by one sample and return the reading it yields.
  function automatic bcvf_pkg::result_t predict_reading(input bcvf_pkg::sample_t item);
    logic [31:0]        dt;
    logic [63:0]        pos;
    logic [63:0]        off;
    logic [63:0]        mag;
    logic [63:0]        q;
    logic signed [31:0] cur_raw;
    logic signed [31:0] volt_raw;
    longint             p;
    bcvf_pkg::result_t  r;
    dt = item.timestamp_us - last_stamp_us;
    last_stamp_us = item.timestamp_us;
    pos = 64'(vref_setting) * 64'(item.current_sample);
    off = 64'(bcvf_pkg::OFFSET_MV) * ADC_FULL;
    if (pos >= off) cur_raw = scale_reading(pos - off, 1'b0, ADC_FULL * 64'(cur_sens_setting));
    else cur_raw = scale_reading(off - pos, 1'b1, ADC_FULL * 64'(cur_sens_setting));
    volt_raw = scale_reading(64'(vref_setting) * 64'(item.voltage_sample), 1'b0,
                             ADC_FULL * 64'(volt_sens_setting));
    current_level_q = smooth_level(current_level_q, cur_raw, dt, cur_tau_setting);
    voltage_level_q = smooth_level(voltage_level_q, volt_raw, dt, volt_tau_setting);
    // Power: product rounded back to Q15.16, half away from zero.
    p = longint'(current_level_q) * longint'(voltage_level_q);
    mag = (p < 0) ? 64'(-p) : 64'(p);
    q = (mag + (64'd1 << (Q_FRAC - 1))) >> Q_FRAC;
    r.current_amps = current_level_q;
    r.voltage_volts = voltage_level_q;
    r.power_watts = (p < 0) ? clamp_q16(-longint'(q)) : clamp_q16(longint'(q));
    return r;
  endfunction

  // Offer one sample after a random gap and hold it until the transaction
  // completes; queue either the hand-typed reading or the predicted one.
  task automatic push_sample(input bcvf_pkg::sample_t item, input bit typed,
                             input bcvf_pkg::result_t typed_want);
    bcvf_pkg::result_t predicted;
    while ($urandom_range(99, 0) < sender_idle_pct) begin
      sample_valid <= 1'b0;
      @(posedge clk);
    end
    sample <= item;
    sample_valid <= 1'b1;
    do @(posedge clk); while (!(sample_valid && !sample_stall));
    predicted = predict_reading(item);
    expected_readings.push_back(typed ? typed_want : predicted);
  endtask

  // Stop offering and wait until every queued reading has come back.
  task automatic drain_results();
    sample_valid <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk);
  endtask

  // Raise the write strobe and update the predictor copy; the caller drops the strobe once the group is done.
  task automatic write_register(input logic [bcvf_pkg::CFG_IDX_W-1:0] idx,
                                input logic [15:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      bcvf_pkg::REG_VREF_MV:   vref_setting = data;
      bcvf_pkg::REG_CUR_SENS:  cur_sens_setting = data;
      bcvf_pkg::REG_VOLT_SENS: volt_sens_setting = data;
      bcvf_pkg::REG_CUR_TAU:   cur_tau_setting = data;
      bcvf_pkg::REG_VOLT_TAU:  volt_tau_setting = data;
      default: ;
    endcase
  endtask

  task automatic load_settings(input logic [15:0] vref_val, input logic [15:0] cur_sens_val,
                               input logic [15:0] volt_sens_val,
                               input logic [15:0] cur_tau_val,
                               input logic [15:0] volt_tau_val);
    drain_results();
    write_register(bcvf_pkg::REG_VREF_MV, vref_val);
    write_register(bcvf_pkg::REG_CUR_SENS, cur_sens_val);
    write_register(bcvf_pkg::REG_VOLT_SENS, volt_sens_val);
    write_register(bcvf_pkg::REG_CUR_TAU, cur_tau_val);
    write_register(bcvf_pkg::REG_VOLT_TAU, volt_tau_val);
    cfg_write <= 1'b0;
  endtask

  // ADC code: mostly uniform, with the rails thrown in now and then.
  function automatic logic [15:0] pick_code();
    int roll;
    roll = $urandom_range(99, 0);
    if (roll < 5) return 16'h0000;
    if (roll < 10) return 16'hFFFF;
    return 16'($urandom_range(65535, 0));
  endfunction

  // Time constant: bypass, short enough for visible gain, or anywhere.
  function automatic logic [15:0] pick_tau();
    case ($urandom_range(2, 0))
      0: return 16'd0;
      1: return 16'($urandom_range(20, 1));
      default: return 16'($urandom_range(65535, 1));
    endcase
  endfunction

  // Receiver: random stall per cycle, or a long counted hold-off on request.
  initial begin
    int hold_left;
    hold_left = 0;
    result_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        result_stall <= 1'b1;
        hold_left--;
      end else if (hold_requested) begin
        hold_requested = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        result_stall <= 1'b1;
      end else begin
        result_stall <= ($urandom_range(99, 0) < stall_pct);
      end
    end
  end

  // Compare each result transaction with the oldest queued reading.
  always @(posedge clk) begin : check_results
    bcvf_pkg::result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (expected_readings.size() == 0) begin
        report_mismatch("result with no sample pending");
      end else begin
        want = expected_readings.pop_front();
        if (result.current_amps !== want.current_amps)
          report_mismatch($sformatf("current_amps got %0d expected %0d",
                                    result.current_amps, want.current_amps));
        if (result.voltage_volts !== want.voltage_volts)
          report_mismatch($sformatf("voltage_volts got %0d expected %0d",
                                    result.voltage_volts, want.voltage_volts));
        if (result.power_watts !== want.power_watts)
          report_mismatch($sformatf("power_watts got %0d expected %0d",
                                    result.power_watts, want.power_watts));
      end
    end
  end

  // Watchdog: count cycles without a transaction on either channel.
  always @(posedge clk) begin
    if (rst || (sample_valid && !sample_stall) || (result_valid && !result_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    logic [31:0]       stamp_us;
    bcvf_pkg::sample_t item;
    int                roll;

    rst <= 1'b1;
    sample_valid <= 1'b0;
    sample <= '0;
    cfg_write <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    vref_setting = bcvf_pkg::RST_VREF_MV;
    cur_sens_setting = bcvf_pkg::RST_CUR_SENS;
    volt_sens_setting = bcvf_pkg::RST_VOLT_SENS;
    cur_tau_setting = '0;
    volt_tau_setting = '0;
    last_stamp_us = '0;
    current_level_q = '0;
    voltage_level_q = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed table; register writes only once the block has gone quiet.
    sender_idle_pct = IDLE_BOTH;
    stall_pct = IDLE_BOTH;
    for (int i = 0; i < NUM_ROWS; i++) begin
      if (DIRECTED_ROWS[i].kind == ROW_WRITE) begin
        drain_results();
        write_register(DIRECTED_ROWS[i].index, DIRECTED_ROWS[i].data);
      end else begin
        cfg_write <= 1'b0;
        push_sample(DIRECTED_ROWS[i].item, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
      end
    end

    // Random phases: new settings each time, rotating through the idling mixes.
    stamp_us = 32'd100000;
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: load_settings(bcvf_pkg::RST_VREF_MV, bcvf_pkg::RST_CUR_SENS,
                         bcvf_pkg::RST_VOLT_SENS, 16'd5, 16'd20);
        1: load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        2: load_settings(16'd1, 16'd1, 16'd1, 16'd0, 16'd0);
        3: load_settings(16'hFFFF, 16'd1, 16'd1, 16'd1, 16'd1);
        default: load_settings(16'($urandom_range(65535, 1)), 16'($urandom_range(65535, 1)),
                               16'($urandom_range(65535, 1)), pick_tau(), pick_tau());
      endcase
      case (phase % 4)
        0: begin
          sender_idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          sender_idle_pct = IDLE_HEAVY;
          stall_pct = 0;
        end
        2: begin
          sender_idle_pct = 0;
          stall_pct = IDLE_HEAVY;
        end
        default: begin
          sender_idle_pct = IDLE_BOTH;
          stall_pct = IDLE_BOTH;
        end
      endcase
      // Start odd phases just short of the wrap so the counter rolls over in-stream.
      if (phase % 2 == 1) stamp_us = 32'hFFFF_FFFF - 32'($urandom_range(100000, 0));

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // Back the block up once while the sender keeps offering.
        if (phase == 0 && n == 20) hold_requested = 1'b1;
        roll = $urandom_range(99, 0);
        if (roll < 80) begin
          stamp_us = stamp_us + 32'($urandom_range(3000, 1));
        end else if (roll < 90) begin
          // repeated timestamp: zero elapsed time
        end else begin
          stamp_us = $urandom();
        end
        item.timestamp_us = stamp_us;
        item.current_sample = pick_code();
        item.voltage_sample = pick_code();
        push_sample(item, 1'b0, '0);
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_readings.size() != 0)
      report_mismatch($sformatf("%0d readings never arrived", expected_readings.size()));

    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
